// ----- rtl/core/min_cost_jump_path_dp_macros.svh -----
// Assertion macros shared by the minimum-cost jump path block.
// Depends on nothing; files that check their own logic include it.
`ifndef MIN_COST_JUMP_PATH_DP_MACROS_SVH
`define MIN_COST_JUMP_PATH_DP_MACROS_SVH

// Concurrent check, switched off while reset is asserted.
`define MCJP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define MCJP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/mcjp_pkg.sv -----
// Shared types, constants and sequencer states of the minimum-cost jump path block.
// Depends on nothing; the interfaces, ring, compare unit, top level and testbench import it.
`default_nettype none

package mcjp_pkg;

    localparam int DEF_MAX_JUMP    = 128;
    localparam int DEF_HEIGHT_BITS = 16;
    localparam int COST_BITS       = 48;
    localparam int CFG_BITS        = 8;

    typedef logic [COST_BITS-1:0] cost_t;
    typedef logic [CFG_BITS-1:0]  jump_cfg_t;

    localparam cost_t     COST_MAX       = '1;
    localparam jump_cfg_t MAX_JUMP_RESET = 8'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    // Sequencer to compare unit.
    typedef struct packed {
        logic clear;
        logic rd_vld;
    } eval_ctl_t;

    // Compare unit back to the sequencer.
    typedef struct packed {
        logic  busy;
        cost_t best;
    } eval_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/mcjp_in_if.sv -----
// Input channel of the jump path block: one height and its start flag per beat.
// Depends on mcjp_pkg.
`default_nettype none

interface mcjp_in_if import mcjp_pkg::*; #(
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) ();
    logic                   valid;
    logic                   ready;
    logic [HEIGHT_BITS-1:0] height;
    logic                   start_new;

    modport source (output valid, output height, output start_new, input ready);
    modport sink   (input valid, input height, input start_new, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mcjp_out_if.sv -----
// Result channel of the jump path block: one best cost per beat.
// Depends on mcjp_pkg.
`default_nettype none

interface mcjp_out_if import mcjp_pkg::*; ();
    logic  valid;
    logic  ready;
    cost_t best_cost;

    modport source (output valid, output best_cost, input ready);
    modport sink   (input valid, input best_cost, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mcjp_cfg_if.sv -----
// Configuration write channel of the jump path block: the max_jump register.
// Depends on mcjp_pkg.
`default_nettype none

interface mcjp_cfg_if import mcjp_pkg::*; ();
    logic      valid;
    logic      ready;
    jump_cfg_t max_jump;

    modport source (output valid, output max_jump, input ready);
    modport sink   (input valid, input max_jump, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mcjp_ring.sv -----
// Ring storage of past heights and best costs, one write and one read port.
// Depends on mcjp_pkg; read data is registered.
`default_nettype none

module mcjp_ring import mcjp_pkg::*; #(
    parameter int DEPTH       = DEF_MAX_JUMP,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
    parameter int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [HEIGHT_BITS-1:0] wheight,
    input  wire cost_t                  wcost,
    input  wire logic [AW-1:0]          raddr,
    output      logic [HEIGHT_BITS-1:0] rheight,
    output      cost_t                  rcost
);

    logic [HEIGHT_BITS-1:0] height_mem [DEPTH];
    cost_t                  cost_mem   [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            height_mem[waddr] <= wheight;
            cost_mem[waddr]   <= wcost;
        end
    end

    always_ff @(posedge clk)
    begin
        rheight <= height_mem[raddr];
        rcost   <= cost_mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/mcjp_eval.sv -----
// Shared compare unit: one predecessor per beat, saturating add, running minimum.
// Depends on mcjp_pkg.
`default_nettype none

module mcjp_eval import mcjp_pkg::*; #(
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire eval_ctl_t              ctl,
    input  wire logic [HEIGHT_BITS-1:0] h,
    input  wire logic [HEIGHT_BITS-1:0] ph,
    input  wire cost_t                  pc,
    output      eval_sts_t              sts
);

    logic [HEIGHT_BITS-1:0] diff;
    logic [COST_BITS:0]     sum_wide;
    cost_t                  sum;
    logic                   s1_vld_reg;
    logic                   s1_vld_next;
    cost_t                  sum_reg;
    cost_t                  best_reg;

    always_comb
    begin
        diff     = (h >= ph) ? (h - ph) : (ph - h);
        sum_wide = {1'b0, pc} + (COST_BITS + 1)'(diff);
        // A saturated cost stays saturated; a carry out also saturates.
        sum = (pc == COST_MAX || sum_wide[COST_BITS]) ? COST_MAX : sum_wide[COST_BITS-1:0];
        s1_vld_next = ctl.rd_vld && !ctl.clear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum;
        if (ctl.clear)
        begin
            best_reg <= COST_MAX;
        end
        else if (s1_vld_reg && (sum_reg < best_reg))
        begin
            best_reg <= sum_reg;
        end
    end

    assign sts.busy = s1_vld_reg;
    assign sts.best = best_reg;

endmodule

`default_nettype wire

// ----- rtl/core/min_cost_jump_path_dp.sv -----
// Top level of the minimum-cost jump path block: sequencer, ring and compare unit.
// Depends on mcjp_pkg, the three channel interfaces, mcjp_ring and mcjp_eval.
//
// Usage:
//   heights: one beat per path position (height, start_new). start_new opens a
//     new sequence whose first position costs zero.
//   costs: one beat per accepted height with the least total cost of reaching
//     that position, saturating at 2^48-1.
//   cfg: writes max_jump (reset value 2); always ready, write only while idle.
// Timing:
//   An accepted height is compared against span = min(max_jump, MAX_JUMP,
//   positions in the sequence) stored predecessors, one ring read per cycle
//   through the single compare unit; with span zero no read is made. heights.ready
//   is low while a height is worked on and returns the cycle after the result is
//   loaded, so the block takes a new height only once the last result is loaded.
// Reset clears the sequencer, the position count, the ring pointer and the
//   result valid flag; the ring contents are not cleared and are never read
//   before being written in the current sequence.
// When costs stalls, the finished result waits in the output register and the
//   block still takes and works on the next height; it holds that second
//   result internally until the output register frees up.
`default_nettype none
`include "min_cost_jump_path_dp_macros.svh"

module min_cost_jump_path_dp import mcjp_pkg::*; #(
    parameter int MAX_JUMP    = DEF_MAX_JUMP,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mcjp_in_if.sink     heights,
    mcjp_out_if.source  costs,
    mcjp_cfg_if.sink    cfg
);

    localparam int AW   = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
    localparam int PS_W = $clog2(MAX_JUMP + 1);

    state_t                 state_reg;
    state_t                 state_next;
    jump_cfg_t              max_jump_reg;
    logic [PS_W-1:0]        pseen_reg;
    logic [PS_W-1:0]        pseen_next;
    logic [AW-1:0]          ptr_reg;
    logic [AW-1:0]          ptr_next;
    logic [AW-1:0]          rd_addr_reg;
    logic [AW-1:0]          rd_addr_next;
    logic [PS_W-1:0]        left_reg;
    logic [PS_W-1:0]        left_next;
    logic                   rd_vld_reg;
    logic                   rd_vld_next;
    logic                   first_reg;
    logic                   first_next;
    logic [HEIGHT_BITS-1:0] h_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    cost_t                  out_cost_reg;
    cost_t                  result;

    logic                   in_fire;
    logic                   slot_free;
    logic [PS_W-1:0]        pseen_eff;
    logic [31:0]            span32;
    logic [PS_W-1:0]        span;
    logic                   we;
    logic [HEIGHT_BITS-1:0] rd_height;
    cost_t                  rd_cost;
    eval_ctl_t              eval_ctl;
    eval_sts_t              eval_sts;

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(MAX_JUMP - 1) : p - AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(MAX_JUMP - 1)) ? '0 : p + AW'(1);
    endfunction

    assign in_fire   = heights.valid && heights.ready;
    assign slot_free = !out_valid_reg || costs.ready;
    assign pseen_eff = heights.start_new ? '0 : pseen_reg;
    assign result    = first_reg ? '0 : eval_sts.best;

    // Number of predecessors to visit: the tightest of the three limits.
    always_comb
    begin
        span32 = 32'(max_jump_reg);
        if (span32 > 32'(MAX_JUMP))
        begin
            span32 = 32'(MAX_JUMP);
        end
        if (span32 > 32'(pseen_eff))
        begin
            span32 = 32'(pseen_eff);
        end
        span = span32[PS_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (span != '0) ? ST_RUN : ST_WRITE;
                end
            end
            ST_RUN:
            begin
                if (left_reg == PS_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !eval_sts.busy)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and datapath control.
    always_comb
    begin
        pseen_next     = pseen_reg;
        ptr_next       = ptr_reg;
        rd_addr_next   = rd_addr_reg;
        left_next      = left_reg;
        rd_vld_next    = 1'b0;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !costs.ready;
        we             = 1'b0;
        eval_ctl.clear = 1'b0;
        eval_ctl.rd_vld = rd_vld_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pseen_next     = pseen_eff;
                    first_next     = (pseen_eff == '0);
                    left_next      = span;
                    rd_addr_next   = ptr_dec(ptr_reg);
                    eval_ctl.clear = 1'b1;
                end
            end
            ST_RUN:
            begin
                rd_vld_next  = 1'b1;
                left_next    = left_reg - PS_W'(1);
                rd_addr_next = ptr_dec(rd_addr_reg);
            end
            ST_DRAIN:
            begin
                rd_vld_next = 1'b0;
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    we             = 1'b1;
                    out_valid_next = 1'b1;
                    ptr_next       = ptr_inc(ptr_reg);
                    if (pseen_reg < PS_W'(MAX_JUMP))
                    begin
                        pseen_next = pseen_reg + PS_W'(1);
                    end
                end
            end
            default:
            begin
                rd_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_jump_reg  <= MAX_JUMP_RESET;
            pseen_reg     <= '0;
            ptr_reg       <= '0;
            rd_addr_reg   <= '0;
            left_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pseen_reg     <= pseen_next;
            ptr_reg       <= ptr_next;
            rd_addr_reg   <= rd_addr_next;
            left_reg      <= left_next;
            rd_vld_reg    <= rd_vld_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                max_jump_reg <= cfg.max_jump;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            h_reg <= heights.height;
        end
        if (we)
        begin
            out_cost_reg <= result;
        end
    end

    assign heights.ready   = (state_reg == ST_IDLE);
    assign costs.valid     = out_valid_reg;
    assign costs.best_cost = out_cost_reg;
    assign cfg.ready       = 1'b1;

    mcjp_ring #(
        .DEPTH       (MAX_JUMP),
        .HEIGHT_BITS (HEIGHT_BITS),
        .AW          (AW)
    ) u_ring (
        .clk     (clk),
        .we      (we),
        .waddr   (ptr_reg),
        .wheight (h_reg),
        .wcost   (result),
        .raddr   (rd_addr_reg),
        .rheight (rd_height),
        .rcost   (rd_cost)
    );

    mcjp_eval #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (eval_ctl),
        .h     (h_reg),
        .ph    (rd_height),
        .pc    (rd_cost),
        .sts   (eval_sts)
    );

    // A new height may only enter once no predecessor is still in flight.
    `MCJP_ASSERT(a_ready_drained, clk, rst_n,
        heights.ready |-> (!rd_vld_reg && !eval_sts.busy),
        "height accepted with compare pipeline busy")
    // The ring is written only after the running minimum has settled.
    `MCJP_ASSERT(a_write_settled, clk, rst_n,
        (state_reg == ST_WRITE) |-> (!rd_vld_reg && !eval_sts.busy),
        "result written before compare pipeline drained")
    // The count is forced to zero while reset is held, before it may be known.
    `MCJP_ASSERT_ALWAYS(a_pseen_bound, clk,
        (!rst_n || (pseen_reg <= PS_W'(MAX_JUMP))),
        "position count exceeds ring depth")
    `MCJP_ASSERT(a_result_loaded, clk, rst_n,
        (state_reg == ST_WRITE && slot_free) |=> (costs.valid && state_reg == ST_IDLE),
        "result not presented after write")
    `MCJP_ASSERT(a_first_zero, clk, rst_n,
        (state_reg == ST_WRITE && slot_free && first_reg) |=> (costs.best_cost == '0),
        "first position of a sequence not zero cost")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for min_cost_jump_path_dp. It streams heights, rewrites
// max_jump between phases and checks every cost beat against its own path-cost predictor.
// Depends on mcjp_pkg, the three channel interfaces and the block's RTL.

module tb_top;
    import mcjp_pkg::*;

    localparam int RING_DEPTH   = DEF_MAX_JUMP;
    localparam int H_BITS       = DEF_HEIGHT_BITS;
    localparam int DRAIN_CYCLES = 2 * (DEF_MAX_JUMP + 5);
    localparam int HOLD_CYCLES  = 400;

    typedef logic [H_BITS-1:0] height_t;

    typedef struct packed {
        height_t height;
        logic    start_new;
    } path_step_t;

    logic clk = 1'b0;
    logic rst_n;

    mcjp_in_if #(.HEIGHT_BITS(H_BITS)) heights_if ();
    mcjp_out_if costs_if ();
    mcjp_cfg_if cfg_if ();

    min_cost_jump_path_dp #(
        .MAX_JUMP    (RING_DEPTH),
        .HEIGHT_BITS (H_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .heights (heights_if),
        .costs   (costs_if),
        .cfg     (cfg_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state: the last heights and best costs of the current sequence.
    height_t   ring_height [RING_DEPTH];
    cost_t     ring_cost [RING_DEPTH];
    int        seq_count  = 0;
    int        next_slot  = 0;
    jump_cfg_t jump_limit = MAX_JUMP_RESET;

    path_step_t step_q [$];
    cost_t      cost_q [$];
    int         steps_left   = 0;
    int         fail_count   = 0;
    logic       in_beat      = 1'b0;
    int         src_gap      = 0;
    int         snk_gap      = 0;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    logic       hold_req     = 1'b0;
    logic       hold_off     = 1'b0;

    function automatic cost_t advance_path(input height_t h, input logic first);
        int                 span;
        int                 slot;
        int                 j;
        cost_t              best;
        height_t            diff;
        logic [COST_BITS:0] sum;
        if (first)
            seq_count = 0;
        best = '0;
        if (seq_count != 0)
        begin
            span = (int'(jump_limit) > RING_DEPTH) ? RING_DEPTH : int'(jump_limit);
            if (span > seq_count)
                span = seq_count;
            best = COST_MAX;
            for (j = 1; j <= span; j++)
            begin
                slot = (next_slot + RING_DEPTH - j) % RING_DEPTH;
                diff = (h >= ring_height[slot]) ? h - ring_height[slot]
                                                : ring_height[slot] - h;
                sum  = {1'b0, ring_cost[slot]} + (COST_BITS + 1)'(diff);
                // A saturated predecessor, or a sum that reaches the top, stays unreachable.
                if (ring_cost[slot] != COST_MAX && sum < {1'b0, COST_MAX}
                        && sum[COST_BITS-1:0] < best)
                    best = sum[COST_BITS-1:0];
            end
        end
        ring_height[next_slot] = h;
        ring_cost[next_slot]   = best;
        next_slot = (next_slot + 1) % RING_DEPTH;
        if (seq_count < RING_DEPTH)
            seq_count++;
        return best;
    endfunction

    // Monitor: predicts on every height beat and checks every cost beat.
    always @(posedge clk)
    begin
        cost_t want;
        in_beat <= heights_if.valid && heights_if.ready;
        if (heights_if.valid && heights_if.ready)
        begin
            cost_q.push_back(advance_path(heights_if.height, heights_if.start_new));
            steps_left--;
        end
        if (costs_if.valid && costs_if.ready)
        begin
            if (cost_q.size() == 0)
            begin
                $error("best_cost beat with nothing outstanding: got %0d", costs_if.best_cost);
                fail_count++;
            end
            else
            begin
                want = cost_q.pop_front();
                if (costs_if.best_cost !== want)
                begin
                    $error("best_cost mismatch: expected %0d, got %0d",
                           want, costs_if.best_cost);
                    fail_count++;
                end
            end
        end
    end

    // Height driver: a beat stays on the channel until the block takes it.
    always @(negedge clk)
    begin
        path_step_t nxt;
        if (!rst_n)
            heights_if.valid <= 1'b0;
        else if (heights_if.valid && !in_beat)
        begin
        end
        else if (src_gap > 0)
        begin
            heights_if.valid <= 1'b0;
            src_gap <= src_gap - 1;
        end
        else if (step_q.size() != 0)
        begin
            nxt = step_q.pop_front();
            heights_if.valid     <= 1'b1;
            heights_if.height    <= nxt.height;
            heights_if.start_new <= nxt.start_new;
            if ($urandom_range(99) < src_idle_pct)
                src_gap <= $urandom_range(7, 1);
        end
        else
            heights_if.valid <= 1'b0;
    end

    // Cost receiver with random stall bursts and one long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            costs_if.ready <= 1'b0;
        else if (snk_gap > 0)
        begin
            costs_if.ready <= 1'b0;
            snk_gap <= snk_gap - 1;
        end
        else
        begin
            costs_if.ready <= 1'b1;
            if ($urandom_range(99) < snk_idle_pct)
                snk_gap <= $urandom_range(7, 1);
        end
    end

    // The long hold-off lets the block fill up and push back on the height channel.
    initial
    begin
        wait (hold_req);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    task automatic push_step(input height_t h, input logic first);
        step_q.push_back('{height: h, start_new: first});
        steps_left++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (steps_left != 0 || cost_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_max_jump(input jump_cfg_t value);
        @(negedge clk);
        cfg_if.valid    <= 1'b1;
        cfg_if.max_jump <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        jump_limit = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_phase(input jump_cfg_t jump, input int count, input logic fresh,
                             input int idle_pct);
        height_t h;
        logic    first;
        int      i;
        wait_drained();
        set_max_jump(jump);
        @(posedge clk);
        src_idle_pct = idle_pct;
        snk_idle_pct = idle_pct;
        h = height_t'($urandom);
        for (i = 0; i < count; i++)
        begin
            first = (i == 0) ? fresh : ($urandom_range(79) == 0);
            case ($urandom_range(9))
                0:       h = $urandom_range(1) ? '1 : '0;
                1, 2, 3: h = height_t'($urandom);
                // Mostly a random walk, so that nearby predecessors compete.
                default: h = h + height_t'($urandom_range(200)) - height_t'(100);
            endcase
            push_step(h, first);
        end
    endtask

    initial
    begin
        int k;
        heights_if.valid     = 1'b0;
        heights_if.height    = '0;
        heights_if.start_new = 1'b0;
        costs_if.ready       = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.max_jump      = '0;
        rst_n                = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset value of max_jump; the very first height has no start flag.
        @(posedge clk);
        src_idle_pct = 30;
        snk_idle_pct = 30;
        push_step(16'd100, 1'b0);
        push_step(16'hFFFF, 1'b0);
        push_step(16'h0000, 1'b0);
        push_step(16'hFFFF, 1'b1);
        push_step(16'h0000, 1'b0);
        push_step(16'hAAAA, 1'b0);
        push_step(16'h5555, 1'b0);
        wait_drained();

        // With no reachable predecessor every later position saturates.
        set_max_jump(8'd0);
        @(posedge clk);
        push_step(16'd5, 1'b1);
        push_step(16'd7, 1'b0);
        push_step(16'd9, 1'b0);
        push_step(16'd9, 1'b0);
        wait_drained();

        // Saturated costs must stay saturated once jumps are allowed again.
        set_max_jump(8'd1);
        @(posedge clk);
        push_step(16'd9, 1'b0);
        push_step(16'd0, 1'b0);
        wait_drained();

        // A jump limit above the ring depth reaches back to the zero-cost start.
        set_max_jump(8'hFF);
        @(posedge clk);
        push_step(16'd3, 1'b0);
        push_step(16'hFFFF, 1'b0);
        push_step(16'h0000, 1'b0);
        wait_drained();

        set_max_jump(8'd128);
        @(posedge clk);
        push_step(16'h8000, 1'b0);
        push_step(16'h7FFF, 1'b1);
        push_step(16'h0001, 1'b0);

        hold_req = 1'b1;
        run_phase(8'd1, 60, 1'b1, 30);
        run_phase(8'd3, 80, 1'b0, 0);
        run_phase(8'd128, 160, 1'b1, 20);
        run_phase(8'hFF, 60, 1'b0, 30);
        run_phase(8'd0, 30, 1'b0, 20);
        run_phase(8'd2, 60, 1'b1, 40);
        run_phase(8'd64, 70, 1'b0, 10);
        for (k = 0; k < 2; k++)
            run_phase(jump_cfg_t'($urandom_range(255, 1)), 60, 1'b1, 30);
        run_phase(8'd5, 80, 1'b0, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- min_cost_jump_path_dp.f -----
+incdir+rtl/core
rtl/core/mcjp_pkg.sv
rtl/core/mcjp_in_if.sv
rtl/core/mcjp_out_if.sv
rtl/core/mcjp_cfg_if.sv
rtl/core/mcjp_ring.sv
rtl/core/mcjp_eval.sv
rtl/core/min_cost_jump_path_dp.sv
tb/tb_top.sv
